// ===== sv/gcwd_pkg.sv =====
package gcwd_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned MethodW = 13;
  localparam int unsigned SubW    = 3;
  localparam int unsigned CountW  = 13;
  localparam int unsigned ModeW   = 3;

  // Header mode codes, taken from bits 31:29 of a header word.
  localparam logic [ModeW-1:0] MODE_OLD_INC  = 3'd0;
  localparam logic [ModeW-1:0] MODE_INC      = 3'd1;
  localparam logic [ModeW-1:0] MODE_INLINE   = 3'd4;
  localparam logic [ModeW-1:0] MODE_INC_ONCE = 3'd5;

  // Result kinds.
  localparam logic KIND_CALL        = 1'b0;
  localparam logic KIND_UNSUPPORTED = 1'b1;

  typedef struct packed {
    logic [MethodW-1:0] current_method;
    logic [SubW-1:0]    current_subchannel;
    logic [CountW-1:0]  words_left;
    logic               hold_method;
    logic               hold_after_first;
  } parse_state_t;

  typedef struct packed {
    logic               result_kind;
    logic [MethodW-1:0] call_method;
    logic [SubW-1:0]    call_subchannel;
    logic [WordW-1:0]   call_argument;
    logic [CountW-1:0]  words_remaining;
  } call_result_t;

endpackage

// ===== sv/gcwd_if.sv =====
interface gcwd_in_if;
  import gcwd_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] command_word;

  modport source (output valid, output command_word, input ready);
  modport sink (input valid, input command_word, output ready);
endinterface

interface gcwd_out_if;
  import gcwd_pkg::*;

  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [MethodW-1:0] call_method;
  logic [SubW-1:0]    call_subchannel;
  logic [WordW-1:0]   call_argument;
  logic [CountW-1:0]  words_remaining;

  modport source (output valid, output result_kind, output call_method,
                  output call_subchannel, output call_argument,
                  output words_remaining, input ready);
  modport sink (input valid, input result_kind, input call_method,
                input call_subchannel, input call_argument,
                input words_remaining, output ready);
endinterface

// ===== sv/gcwd_decode.sv =====
module gcwd_decode (
  input  gcwd_pkg::parse_state_t          st,
  input  logic [gcwd_pkg::WordW-1:0]      word,
  output gcwd_pkg::parse_state_t          st_nxt,
  output logic                            emit,
  output gcwd_pkg::call_result_t          res
);
  import gcwd_pkg::*;

  logic [MethodW-1:0] h_method;
  logic [SubW-1:0]    h_sub;
  logic [CountW-1:0]  h_count;
  logic [ModeW-1:0]   h_mode;

  assign h_method = word[MethodW-1:0];
  assign h_sub    = word[MethodW +: SubW];
  assign h_count  = word[16 +: CountW];
  assign h_mode   = word[WordW-1 -: ModeW];

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    res    = '0;
    if (st.words_left != '0) begin
      // Data word: one call, then advance the method unless it is held.
      emit                = 1'b1;
      res.result_kind     = KIND_CALL;
      res.call_method     = st.current_method;
      res.call_subchannel = st.current_subchannel;
      res.call_argument   = word;
      res.words_remaining = st.words_left;
      if (!st.hold_method) begin
        st_nxt.current_method = st.current_method + MethodW'(1);
      end
      if (st.hold_after_first) begin
        st_nxt.hold_method = 1'b1;
      end
      st_nxt.words_left = st.words_left - CountW'(1);
    end else begin
      case (h_mode)
        MODE_INC, MODE_INC_ONCE: begin
          st_nxt.current_method     = h_method;
          st_nxt.current_subchannel = h_sub;
          st_nxt.words_left         = h_count;
          st_nxt.hold_method        = 1'b0;
          st_nxt.hold_after_first   = (h_mode == MODE_INC_ONCE);
        end
        MODE_INLINE: begin
          st_nxt.current_method     = h_method;
          st_nxt.current_subchannel = h_sub;
          st_nxt.hold_method        = 1'b1;
          st_nxt.hold_after_first   = 1'b0;
          emit                      = 1'b1;
          res.result_kind           = KIND_CALL;
          res.call_method           = h_method;
          res.call_subchannel       = h_sub;
          res.call_argument         = WordW'(h_count);
          res.words_remaining       = '0;
        end
        MODE_OLD_INC: begin
          emit = 1'b0;
        end
        default: begin
          emit                = 1'b1;
          res.result_kind     = KIND_UNSUPPORTED;
          res.call_method     = h_method;
          res.call_subchannel = h_sub;
          res.call_argument   = word;
          res.words_remaining = '0;
        end
      endcase
    end
  end

endmodule

// ===== sv/gpu_command_word_method_decoder.sv =====
// A result appears on the output channel in the cycle after its command word transfers.
// Throughput: one command word per cycle; the only limit is the single output register,
// which takes a new result in the same cycle that the old one transfers out.
// Reset: synchronous, active-low rst_n clears the parser state (method, subchannel,
// pending count and hold flags) to zero and empties the output register.
module gpu_command_word_method_decoder (
  input  logic        clk,
  input  logic        rst_n,
  gcwd_in_if.sink     in_chan,
  gcwd_out_if.source  out_chan
);
  import gcwd_pkg::*;

  // Parser state. A word is a data word exactly when words_left is nonzero,
  // otherwise it is decoded as a header.
  parse_state_t st_r;
  parse_state_t st_nxt;

  // Output register holding one finished result until it transfers.
  logic         out_vld_r;
  call_result_t out_r;

  logic         in_fire;
  logic         dec_emit;
  call_result_t dec_res;

  // The output register frees up when it is empty or its result transfers in
  // this cycle, so a steady stream moves one word per clock.
  assign in_chan.ready = !out_vld_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // All decoding is short combinational logic from the incoming word and the
  // current state; the next state and the result are captured at the transfer.
  gcwd_decode u_decode (
    .st     (st_r),
    .word   (in_chan.command_word),
    .st_nxt (st_nxt),
    .emit   (dec_emit),
    .res    (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (in_chan.ready) begin
        // A word that produces nothing (incrementing-mode headers or old-mode headers) leaves
        // the register empty.
        out_vld_r <= in_fire && dec_emit;
      end
    end
  end

  // Payload needs no reset; it is qualified by out_vld_r.
  always_ff @(posedge clk) begin
    if (in_fire && dec_emit) begin
      out_r <= dec_res;
    end
  end

  assign out_chan.valid           = out_vld_r;
  assign out_chan.result_kind     = out_r.result_kind;
  assign out_chan.call_method     = out_r.call_method;
  assign out_chan.call_subchannel = out_r.call_subchannel;
  assign out_chan.call_argument   = out_r.call_argument;
  assign out_chan.words_remaining = out_r.words_remaining;

  // A data word always yields a regular method call in the next cycle.
  a_data_word_calls: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (st_r.words_left != '0) |=> out_vld_r && (out_r.result_kind == KIND_CALL))
    else $error("data word did not produce a method call");

  // Each data word consumes exactly one pending count.
  a_count_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (st_r.words_left != '0) |=>
      st_r.words_left == $past(st_r.words_left) - CountW'(1))
    else $error("pending word count did not decrement");

  // An unsupported-mode report never carries a pending count.
  a_unsupported_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.result_kind == KIND_UNSUPPORTED) |-> out_r.words_remaining == '0)
    else $error("unsupported-mode report with nonzero count");

  // A word transferred while no data is pending leaves the state untouched
  // when it produces an unsupported-mode report.
  a_unsupported_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (st_r.words_left == '0) && dec_emit && (dec_res.result_kind == KIND_UNSUPPORTED)
      |=> st_r == $past(st_r))
    else $error("unsupported header changed parser state");

endmodule
